FILE: rtl/core/imhq_pkg.sv
// Shared codes and types for the indexed min-heap queue.
package imhq_pkg;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_DECREASE = 3'd2;
  localparam logic [2:0] CMD_LOAD     = 3'd3;
  localparam logic [2:0] CMD_BUILD    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_ID        = 3'd3;
  localparam logic [2:0] ST_NOT_LESS  = 3'd4;

  localparam int ID_BITS  = 8;
  localparam int ID_COUNT = 256;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_UP   = 16'h0002,
    S_UPC  = 16'h0004,
    S_PUT  = 16'h0008,
    S_DN   = 16'h0010,
    S_DNL  = 16'h0020,
    S_DNR  = 16'h0040,
    S_DNM  = 16'h0080,
    S_RM0  = 16'h0100,
    S_RM1  = 16'h0200,
    S_DK0  = 16'h0400,
    S_DK1  = 16'h0800,
    S_BLD  = 16'h1000,
    S_BLD1 = 16'h2000,
    S_ROOT = 16'h4000,
    S_FIN  = 16'h8000
  } state_t;

endpackage

FILE: rtl/core/imhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/indexed_min_heap_queue.sv
// Indexed binary min-heap queue: sequencer, shared key comparator and heap/map memories.
// One command is in flight at a time; in_stall stays high from the transfer until the
// result has been taken. Each sift-up level costs one memory read and one compare; each
// sift-down level costs up to two reads and two compares, all through a single shared
// comparator. Build sifts down every inner node in turn. Load, full, duplicate, empty and
// absent-id rejections and unused codes go straight to the finish state; a decrease whose
// key is not smaller first reads the map and the heap entry, and build of a single entry
// reads the root.
module indexed_min_heap_queue #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  item_id,
  input  logic [31:0] key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_id,
  output logic [31:0] out_key,
  output logic [8:0]  entry_total
);
  import imhq_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = ID_BITS + KEY_BITS;

  state_t state;
  logic [ID_BITS-1:0]  id_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CW-1:0]       count;
  logic [SW-1:0]       pos;
  logic [ID_BITS-1:0]  cur_id;
  logic [KEY_BITS-1:0] cur_key;
  logic                b_self;
  logic [SW-1:0]       b_slot;
  logic [ID_BITS-1:0]  b_id;
  logic [KEY_BITS-1:0] b_key;
  logic [SW-1:0]       bi;
  logic                build_mode;
  logic [ID_COUNT-1:0] present;

  logic                h_we, h_re, m_we, m_re;
  logic [SW-1:0]       h_waddr, h_raddr, m_wdata;
  logic [HW-1:0]       h_wdata, h_rdata;
  logic [ID_BITS-1:0]  m_waddr, m_raddr;
  logic [SW-1:0]       m_rdata;

  logic [ID_BITS-1:0]  rd_id;
  logic [KEY_BITS-1:0] rd_key;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                lt;
  logic                accept;

  logic [KEY_BITS+31:0] key_in_ext;
  logic [KEY_BITS-1:0]  key_in;
  logic [KEY_BITS+31:0] rd_key_ext, key_r_ext;
  logic [CW+8:0]        count_ext;
  logic [SW+1:0]        l_w, r_w, cnt_w, s_w;
  logic [SW-1:0]        parent;

  assign key_in_ext = {{KEY_BITS{1'b0}}, key};
  assign key_in     = key_in_ext[KEY_BITS-1:0];
  assign rd_id      = h_rdata[HW-1:KEY_BITS];
  assign rd_key     = h_rdata[KEY_BITS-1:0];
  assign rd_key_ext = {32'b0, rd_key};
  assign key_r_ext  = {32'b0, key_r};
  assign count_ext  = {9'b0, count};
  assign l_w        = {1'b0, pos, 1'b1};
  assign r_w        = l_w + 1'b1;
  assign cnt_w      = (SW+2)'(count);
  assign s_w        = (SW+2)'(m_rdata);
  assign parent     = SW'((pos - 1'b1) >> 1);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign lt       = cmp_a < cmp_b;

  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  imhq_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  always_comb begin
    cmp_a = cur_key;
    cmp_b = rd_key;
    unique case (state)
      S_DNL:   begin cmp_a = rd_key; cmp_b = cur_key; end
      S_DNR:   begin cmp_a = rd_key; cmp_b = b_key;   end
      S_DK1:   begin cmp_a = key_r;  cmp_b = rd_key;  end
      default: begin cmp_a = cur_key; cmp_b = rd_key; end
    endcase
  end

  always_comb begin
    h_we = 1'b0; h_waddr = pos; h_wdata = {cur_id, cur_key};
    h_re = 1'b0; h_raddr = '0;
    m_we = 1'b0; m_waddr = cur_id; m_wdata = pos;
    m_re = 1'b0; m_raddr = item_id;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_REMOVE && count != '0) begin
            h_re = 1'b1;
          end
          if (command == CMD_DECREASE && present[item_id]) begin
            m_re = 1'b1;
          end
          if (command == CMD_BUILD && count == CW'(1)) begin
            h_re = 1'b1;
          end
          if (command == CMD_LOAD && count < CW'(CAPACITY) && !present[item_id]) begin
            h_we = 1'b1; h_waddr = SW'(count); h_wdata = {item_id, key_in};
            m_we = 1'b1; m_waddr = item_id;   m_wdata = SW'(count);
          end
        end
      end
      S_UP: begin
        if (pos != '0) begin
          h_re = 1'b1; h_raddr = parent;
        end
      end
      S_UPC: begin
        if (lt) begin
          h_we = 1'b1; h_wdata = h_rdata;
          m_we = 1'b1; m_waddr = rd_id;
        end
      end
      S_PUT: begin
        h_we = 1'b1;
        m_we = 1'b1;
      end
      S_DN: begin
        if (l_w < cnt_w) begin
          h_re = 1'b1; h_raddr = SW'(l_w);
        end
      end
      S_DNL: begin
        if (r_w < cnt_w) begin
          h_re = 1'b1; h_raddr = SW'(r_w);
        end
      end
      S_DNM: begin
        if (!b_self) begin
          h_we = 1'b1; h_wdata = {b_id, b_key};
          m_we = 1'b1; m_waddr = b_id;
        end
      end
      S_RM0: begin
        if (count != '0) begin
          h_re = 1'b1; h_raddr = SW'(count);
        end
      end
      S_DK0: begin
        if (s_w < cnt_w) begin
          h_re = 1'b1; h_raddr = m_rdata;
        end
      end
      S_BLD: begin
        h_re = 1'b1;
        h_raddr = (bi == '0) ? '0 : bi - 1'b1;
      end
      default: begin
        h_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      present    <= '0;
      out_valid  <= 1'b0;
      build_mode <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_r       <= item_id;
            key_r      <= key_in;
            build_mode <= 1'b0;
            status     <= ST_OK;
            out_id     <= item_id;
            out_key    <= '0;
            state      <= S_FIN;
            unique case (command)
              CMD_INSERT, CMD_LOAD: begin
                out_key <= key_in_ext[31:0];
                if (count >= CW'(CAPACITY)) begin
                  status <= ST_FULL;
                end else if (present[item_id]) begin
                  status <= ST_ID;
                end else begin
                  present[item_id] <= 1'b1;
                  count            <= count + 1'b1;
                  pos              <= SW'(count);
                  cur_id           <= item_id;
                  cur_key          <= key_in;
                  if (command == CMD_INSERT) begin
                    state <= S_UP;
                  end
                end
              end
              CMD_REMOVE: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  count <= count - 1'b1;
                  state <= S_RM0;
                end
              end
              CMD_DECREASE: begin
                if (!present[item_id]) begin
                  status  <= ST_ID;
                  out_key <= key_in_ext[31:0];
                end else begin
                  state <= S_DK0;
                end
              end
              CMD_BUILD: begin
                if (count >= CW'(2)) begin
                  bi         <= SW'(count >> 1);
                  build_mode <= 1'b1;
                  state      <= S_BLD;
                end else if (count == CW'(1)) begin
                  state <= S_ROOT;
                end
              end
              default: begin
                status <= ST_OK;
              end
            endcase
          end
        end
        S_UP: begin
          state <= (pos == '0) ? S_PUT : S_UPC;
        end
        S_UPC: begin
          if (lt) begin
            pos   <= parent;
            state <= S_UP;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          state <= build_mode ? S_BLD : S_FIN;
        end
        S_DN: begin
          state <= (l_w < cnt_w) ? S_DNL : S_PUT;
        end
        S_DNL: begin
          b_self <= !lt;
          b_slot <= SW'(l_w);
          b_id   <= lt ? rd_id : cur_id;
          b_key  <= lt ? rd_key : cur_key;
          state  <= (r_w < cnt_w) ? S_DNR : S_DNM;
        end
        S_DNR: begin
          if (lt) begin
            b_self <= 1'b0;
            b_slot <= SW'(r_w);
            b_id   <= rd_id;
            b_key  <= rd_key;
          end
          state <= S_DNM;
        end
        S_DNM: begin
          if (b_self) begin
            state <= S_PUT;
          end else begin
            pos   <= b_slot;
            state <= S_DN;
          end
        end
        S_RM0: begin
          out_id         <= rd_id;
          out_key        <= rd_key_ext[31:0];
          present[rd_id] <= 1'b0;
          state          <= (count != '0) ? S_RM1 : S_FIN;
        end
        S_RM1: begin
          cur_id  <= rd_id;
          cur_key <= rd_key;
          pos     <= '0;
          state   <= S_DN;
        end
        S_DK0: begin
          pos <= m_rdata;
          if (s_w < cnt_w) begin
            state <= S_DK1;
          end else begin
            status  <= ST_ID;
            out_key <= key_r_ext[31:0];
            state   <= S_FIN;
          end
        end
        S_DK1: begin
          if (lt) begin
            cur_id  <= id_r;
            cur_key <= key_r;
            out_key <= key_r_ext[31:0];
            state   <= S_UP;
          end else begin
            status  <= ST_NOT_LESS;
            out_key <= rd_key_ext[31:0];
            state   <= S_FIN;
          end
        end
        S_BLD: begin
          if (bi == '0) begin
            build_mode <= 1'b0;
            state      <= S_ROOT;
          end else begin
            bi    <= bi - 1'b1;
            pos   <= bi - 1'b1;
            state <= S_BLD1;
          end
        end
        S_BLD1: begin
          cur_id  <= rd_id;
          cur_key <= rd_key;
          state   <= S_DN;
        end
        S_ROOT: begin
          out_key <= rd_key_ext[31:0];
          state   <= S_FIN;
        end
        S_FIN: begin
          entry_total <= count_ext[8:0];
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE || out_valid))
    else $error("transfer did not start a command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> out_valid)
    else $error("finished command produced no result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full status with room left");

endmodule
